// ----- hw/rtl/bars_pkg.sv -----
package bars_pkg;

  localparam int ROW_PIXELS_MAX_DEF = 4096;
  localparam int RUN_W = 13;
  localparam int RUN_CAP_MAX = 8191;

  localparam int SUM_W = 15;
  localparam int PROD_W = 28;
  localparam logic [SUM_W-1:0] WEIGHT_RED = 15'd30;
  localparam logic [SUM_W-1:0] WEIGHT_GREEN = 15'd59;
  localparam logic [SUM_W-1:0] WEIGHT_BLUE = 15'd11;
  // The grey level is floor(sum / 100), taken as (sum * 5243) >> 19.
  localparam logic [PROD_W-1:0] RECIP_100 = 28'd5243;
  localparam int RECIP_SHIFT = 19;

  localparam int GREY_THR_W = 9;
  localparam int RUN_THR_W = 16;
  localparam logic [GREY_THR_W-1:0] GREY_THR_RESET = 9'd128;
  localparam logic [RUN_THR_W-1:0] RUN_THR_RESET = 16'd8;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_GREY_THR = 1'b0;
  localparam logic REG_RUN_THR = 1'b1;

  localparam int QUEUE_DEPTH = 4;

  localparam logic COLOR_WHITE = 1'b0;
  localparam logic COLOR_BLACK = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_last;
  } pix_t;

  typedef struct packed {
    logic             run_color;
    logic [RUN_W-1:0] run_length;
    logic             row_end;
  } run_t;

  typedef struct packed {
    logic black;
    logic last;
  } cls_t;

endpackage

// ----- hw/rtl/bars_front.sv -----
module bars_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  pix_valid,
  input  bars_pkg::pix_t                        pix,
  output logic                                  pix_stall,
  input  logic [bars_pkg::GREY_THR_W-1:0]       grey_threshold,
  input  logic                                  queue_full,
  output logic                                  push,
  output bars_pkg::cls_t                        push_data
);

  logic                           s1_valid;
  logic [bars_pkg::SUM_W-1:0]     s1_sum;
  logic                           s1_last;
  logic                           s2_valid;
  logic [bars_pkg::PROD_W-1:0]    s2_prod;
  logic                           s2_last;
  logic                           adv1;
  logic                           adv2;
  logic [7:0]                     grey;

  assign push = s2_valid && !queue_full;
  assign adv2 = !s2_valid || push;
  assign adv1 = !s1_valid || adv2;
  assign pix_stall = !adv1;

  assign grey = s2_prod[bars_pkg::RECIP_SHIFT +: 8];
  assign push_data.black = {1'b0, grey} < grey_threshold;
  assign push_data.last = s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= pix_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_sum <= bars_pkg::SUM_W'(pix.red) * bars_pkg::WEIGHT_RED
              + bars_pkg::SUM_W'(pix.green) * bars_pkg::WEIGHT_GREEN
              + bars_pkg::SUM_W'(pix.blue) * bars_pkg::WEIGHT_BLUE;
      s1_last <= pix.row_last;
    end
    if (adv2) begin
      s2_prod <= bars_pkg::PROD_W'(s1_sum) * bars_pkg::RECIP_100;
      s2_last <= s1_last;
    end
  end

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> s1_valid && s2_valid && queue_full)
    else $error("front stalls without a full pipeline");

endmodule

// ----- hw/rtl/bars_queue.sv -----
module bars_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bars_pkg::cls_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output bars_pkg::cls_t head_data
);

  localparam int PTR_W = $clog2(bars_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(bars_pkg::QUEUE_DEPTH + 1);

  bars_pkg::cls_t     entries [bars_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full = count == CNT_W'(bars_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_data = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(bars_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(bars_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(bars_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds depth");

endmodule

// ----- hw/rtl/bars_back.sv -----
module bars_back #(
  parameter int ROW_PIXELS_MAX = bars_pkg::ROW_PIXELS_MAX_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [bars_pkg::RUN_THR_W-1:0]       run_threshold,
  input  logic                                 head_valid,
  input  bars_pkg::cls_t                       head_data,
  output logic                                 pop,
  output logic                                 run_valid,
  output bars_pkg::run_t                       run,
  input  logic                                 run_stall
);

  localparam int RW = bars_pkg::RUN_W;
  localparam logic [RW-1:0] RUN_CAP = RW'((ROW_PIXELS_MAX > bars_pkg::RUN_CAP_MAX) ?
                                          bars_pkg::RUN_CAP_MAX : ROW_PIXELS_MAX);
  localparam int CMP_W = bars_pkg::RUN_THR_W + 1;

  logic [RW-1:0]   pending_whites;
  logic            black_seen;
  logic [RW-1:0]   black_run;
  logic [RW-1:0]   pending_whites_next;
  logic            black_seen_next;
  logic [RW-1:0]   black_run_next;

  logic            sec_valid;
  bars_pkg::run_t  sec;
  logic            out_free;

  logic            mid_valid;
  bars_pkg::run_t  mid_run;
  logic            lb_valid;
  bars_pkg::run_t  lb_run;
  logic            lw_valid;
  bars_pkg::run_t  lw_run;
  bars_pkg::run_t  r0;
  bars_pkg::run_t  r1;
  logic [1:0]      n_runs;

  logic [RW-1:0]   pw_inc;
  logic [RW-1:0]   br_inc;
  logic [RW-1:0]   br_fill;
  logic [CMP_W-1:0] thr_ext;

  function automatic logic [RW-1:0] sat_add(input logic [RW-1:0] a, input logic [RW-1:0] b,
                                            input logic [RW-1:0] cap);
    logic [RW:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = (s > {1'b0, cap}) ? cap : s[RW-1:0];
  endfunction

  assign thr_ext = {1'b0, run_threshold};
  assign pw_inc = sat_add(pending_whites, RW'(1), RUN_CAP);
  assign br_inc = sat_add(black_run, RW'(1), RUN_CAP);
  assign br_fill = sat_add(black_run, pw_inc, RUN_CAP);

  always_comb begin
    mid_valid = 1'b0;
    mid_run = '0;
    pending_whites_next = pending_whites;
    black_seen_next = black_seen;
    black_run_next = black_run;
    if (head_data.black) begin
      if (black_seen && pending_whites == '0) begin
        black_run_next = br_inc;
      end else if (black_seen &&
                   (CMP_W'(pending_whites) + CMP_W'(2) <= thr_ext)) begin
        black_run_next = br_fill;
      end else begin
        mid_valid = pending_whites != '0;
        mid_run = '{run_color: bars_pkg::COLOR_WHITE, run_length: pending_whites,
                    row_end: 1'b0};
        black_run_next = RW'(1);
      end
      pending_whites_next = '0;
      black_seen_next = 1'b1;
    end else begin
      pending_whites_next = pw_inc;
      if (black_seen && (CMP_W'(pw_inc) + CMP_W'(2) > thr_ext)) begin
        mid_valid = 1'b1;
        mid_run = '{run_color: bars_pkg::COLOR_BLACK, run_length: black_run, row_end: 1'b0};
        black_seen_next = 1'b0;
        black_run_next = '0;
      end
    end

    lb_valid = head_data.last && black_seen_next;
    lb_run = '{run_color: bars_pkg::COLOR_BLACK, run_length: black_run_next,
               row_end: pending_whites_next == '0};
    lw_valid = head_data.last && pending_whites_next != '0;
    lw_run = '{run_color: bars_pkg::COLOR_WHITE, run_length: pending_whites_next,
               row_end: 1'b1};
    if (head_data.last) begin
      pending_whites_next = '0;
      black_seen_next = 1'b0;
      black_run_next = '0;
    end

    r0 = mid_valid ? mid_run : (lb_valid ? lb_run : lw_run);
    r1 = (mid_valid && lb_valid) ? lb_run : lw_run;
    n_runs = 2'(mid_valid) + 2'(lb_valid) + 2'(lw_valid);
  end

  assign out_free = !run_valid || !run_stall;
  assign pop = head_valid && (n_runs == 2'd0 || (!sec_valid && out_free));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_whites <= '0;
      black_seen <= 1'b0;
      black_run <= '0;
      run_valid <= 1'b0;
      sec_valid <= 1'b0;
    end else begin
      if (pop) begin
        pending_whites <= pending_whites_next;
        black_seen <= black_seen_next;
        black_run <= black_run_next;
      end
      if (sec_valid && out_free) begin
        run_valid <= 1'b1;
        sec_valid <= 1'b0;
      end else if (pop && n_runs != 2'd0) begin
        run_valid <= 1'b1;
        sec_valid <= n_runs == 2'd2;
      end else if (out_free) begin
        run_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sec_valid && out_free) begin
      run <= sec;
    end else if (pop && n_runs != 2'd0) begin
      run <= r0;
      sec <= r1;
    end
  end

  a_sec_behind_out: assert property (@(posedge clk) disable iff (rst)
    sec_valid |-> run_valid)
    else $error("second run held without a run on the output");

  a_black_run_open: assert property (@(posedge clk) disable iff (rst)
    black_seen == (black_run != '0))
    else $error("open black run and its length disagree");

endmodule

// ----- hw/rtl/binarize_and_row_run_smoother.sv -----
// Each pixel passes the front stages s1 and s2 and the queue before its runs are registered on the output.
// Throughput: one pixel per cycle while pix_stall is low; a pixel that closes two runs puts them
// on the output register in turn, and the 4-entry queue absorbs the difference.
// Reset (rst, synchronous, active high) empties the pipeline and queue, clears
// the row state, and sets grey_threshold to 128 and run_threshold to 8.
module binarize_and_row_run_smoother #(
  parameter int ROW_PIXELS_MAX = bars_pkg::ROW_PIXELS_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pix_valid,
  input  bars_pkg::pix_t                 pix,
  output logic                           pix_stall,
  output logic                           run_valid,
  output bars_pkg::run_t                 run,
  input  logic                           run_stall,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bars_pkg::ADDR_W-1:0]    paddr,
  input  logic [bars_pkg::DATA_W-1:0]    pwdata,
  output logic [bars_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  logic [bars_pkg::GREY_THR_W-1:0] grey_threshold;
  logic [bars_pkg::RUN_THR_W-1:0]  run_threshold;
  logic                            cfg_write;
  logic                            queue_full;
  logic                            push;
  bars_pkg::cls_t                  push_data;
  logic                            pop;
  logic                            head_valid;
  bars_pkg::cls_t                  head_data;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      grey_threshold <= bars_pkg::GREY_THR_RESET;
      run_threshold <= bars_pkg::RUN_THR_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        bars_pkg::REG_GREY_THR: grey_threshold <= pwdata[bars_pkg::GREY_THR_W-1:0];
        bars_pkg::REG_RUN_THR:  run_threshold <= pwdata[bars_pkg::RUN_THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bars_pkg::REG_GREY_THR: prdata = bars_pkg::DATA_W'(grey_threshold);
      bars_pkg::REG_RUN_THR:  prdata = bars_pkg::DATA_W'(run_threshold);
      default:                prdata = '0;
    endcase
  end

  bars_front u_front (
    .clk            (clk),
    .rst            (rst),
    .pix_valid      (pix_valid),
    .pix            (pix),
    .pix_stall      (pix_stall),
    .grey_threshold (grey_threshold),
    .queue_full     (queue_full),
    .push           (push),
    .push_data      (push_data)
  );

  bars_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  bars_back #(
    .ROW_PIXELS_MAX (ROW_PIXELS_MAX)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .run_threshold (run_threshold),
    .head_valid    (head_valid),
    .head_data     (head_data),
    .pop           (pop),
    .run_valid     (run_valid),
    .run           (run),
    .run_stall     (run_stall)
  );

endmodule
